[rtl/sxf_pkg.sv]
// Shared constants, types and helper functions for the sprite XOR framebuffer.
`default_nettype none

package sxf_pkg;

  // Default screen geometry
  localparam int unsigned SCREEN_WIDTH  = 64;
  localparam int unsigned SCREEN_HEIGHT = 32;

  // Field widths fixed by the interface
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned COORD_W  = 8;
  localparam int unsigned ROFF_W   = 4;
  localparam int unsigned SPRITE_W = 8;
  localparam int unsigned PIXEL_W  = 64;

  // Command codes
  localparam logic [CMD_W-1:0] CmdClear = 2'd0;
  localparam logic [CMD_W-1:0] CmdDraw  = 2'd1;
  localparam logic [CMD_W-1:0] CmdRead  = 2'd2;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
  } ctl_t;

  // Remainder of an 8-bit value by a constant divisor of at least 8,
  // by restoring subtraction of shifted divisor multiples.
  function automatic logic [COORD_W-1:0] mod_const(input logic [COORD_W-1:0] value,
                                                   input int unsigned divisor);
    int unsigned rem;
    int unsigned step;
    rem = int'(value);
    for (int k = 5; k >= 0; k--) begin
      step = divisor << k;
      if (rem >= step) begin
        rem = rem - step;
      end
    end
    return COORD_W'(rem);
  endfunction

endpackage

`default_nettype wire

[rtl/sxf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sxf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/sxf_ctrl.sv]
// Controller: accept handshake, two-state sequencer and output word valid.
`default_nettype none

module sxf_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output sxf_pkg::ctl_t    ctl_o
);

  sxf_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_blocked;
  logic            accept;

  // Take a new word only when the result register frees up by the next edge
  assign out_blocked = out_valid_q && out_stall_i;
  assign accept      = (state_q == sxf_pkg::ST_IDLE) && in_valid_i && !out_blocked;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sxf_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = sxf_pkg::ST_EXEC;
        end
      end
      sxf_pkg::ST_EXEC: begin
        state_d = sxf_pkg::ST_IDLE;
      end
      default: begin
        state_d = sxf_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    ctl_o.capture = 1'b0;
    ctl_o.exec    = 1'b0;
    in_stall_o    = 1'b1;
    case (state_q)
      sxf_pkg::ST_IDLE: begin
        ctl_o.capture = accept;
        in_stall_o    = out_blocked;
      end
      sxf_pkg::ST_EXEC: begin
        ctl_o.exec = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Set result valid on execute, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == sxf_pkg::ST_EXEC) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sxf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/sxf_datapath.sv]
// Datapath: coordinate wrap, framebuffer read-modify-write, collision and result.
`default_nettype none

module sxf_datapath #(
  parameter int unsigned SCREEN_WIDTH  = sxf_pkg::SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = sxf_pkg::SCREEN_HEIGHT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sxf_pkg::ctl_t                 ctl_i,
  input  wire logic [sxf_pkg::CMD_W-1:0]     command_i,
  input  wire logic [sxf_pkg::COORD_W-1:0]   start_x_i,
  input  wire logic [sxf_pkg::COORD_W-1:0]   start_y_i,
  input  wire logic [sxf_pkg::ROFF_W-1:0]    row_offset_i,
  input  wire logic [sxf_pkg::SPRITE_W-1:0]  row_bits_i,
  input  wire logic                          last_row_i,
  output logic                               collision_o,
  output logic      [sxf_pkg::PIXEL_W-1:0]   pixel_row_o,
  output logic                               sprite_done_o
);

  localparam int unsigned W  = SCREEN_WIDTH;
  localparam int unsigned H  = SCREEN_HEIGHT;
  localparam int unsigned AW = $clog2(H);
  localparam int unsigned XW = $clog2(W);
  localparam int unsigned LW = $clog2(H + 16);
  localparam int unsigned PW = sxf_pkg::PIXEL_W;
  localparam int unsigned SW = sxf_pkg::SPRITE_W;

  // Captured item
  logic [sxf_pkg::CMD_W-1:0] cmd_q;
  logic [XW-1:0]             x0_q;
  logic [LW-1:0]             line_q, line_d;
  logic [SW-1:0]             bits_q;
  logic                      last_q;

  // Sprite state and result register
  logic                      acc_q, acc_d;
  logic                      col_q;
  logic [PW-1:0]             pix_q;
  logic                      done_q;
  logic [H-1:0]              valid_q;

  logic [sxf_pkg::COORD_W-1:0] x0_full, y0_full;
  logic [W-1:0]              rdata, old_row, spr_row;
  logic [PW-1:0]             spr_wide;
  logic                      in_range, is_draw, is_read, is_clear;
  logic                      hit, col_new, row_valid, we;

  // Wrap coordinates and form the target line on accept
  always_comb begin
    x0_full = sxf_pkg::mod_const(start_x_i, W);
    y0_full = sxf_pkg::mod_const(start_y_i, H);
    if (command_i == sxf_pkg::CmdDraw) begin
      line_d = LW'(y0_full) + LW'(row_offset_i);
    end else begin
      line_d = LW'(y0_full);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q  <= command_i;
      x0_q   <= XW'(x0_full);
      line_q <= line_d;
      bits_q <= row_bits_i;
      last_q <= last_row_i;
    end
  end

  // Framebuffer lines
  sxf_ram #(
    .WIDTH (W),
    .DEPTH (H)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (line_q[AW-1:0]),
    .wdata_i (old_row ^ spr_row),
    .re_i    (ctl_i.capture),
    .raddr_i (line_d[AW-1:0]),
    .rdata_o (rdata)
  );

  // Merge sprite with the old line; lines never written since a clear read as zero
  always_comb begin
    is_clear  = cmd_q == sxf_pkg::CmdClear;
    is_draw   = cmd_q == sxf_pkg::CmdDraw;
    is_read   = cmd_q == sxf_pkg::CmdRead;
    in_range  = line_q < LW'(H);
    row_valid = in_range && valid_q[line_q[AW-1:0]];
    old_row   = row_valid ? rdata : '0;
    spr_wide  = {bits_q, {(PW - SW){1'b0}}} >> x0_q;
    spr_row   = spr_wide[PW-1 -: W];
    hit       = is_draw && in_range && (|(old_row & spr_row));
    col_new   = acc_q || hit;
    we        = ctl_i.exec && is_draw && in_range;
    acc_d     = acc_q;
    if (ctl_i.exec && is_draw) begin
      acc_d = last_q ? 1'b0 : col_new;
    end
  end

  // Line valid bits and collision accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      acc_q   <= 1'b0;
    end else begin
      acc_q <= acc_d;
      if (ctl_i.exec && is_clear) begin
        valid_q <= '0;
      end else if (we) begin
        valid_q[line_q[AW-1:0]] <= 1'b1;
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      col_q  <= is_draw && col_new;
      done_q <= is_draw && last_q;
      pix_q  <= is_read ? (PW'(old_row) << (PW - W)) : '0;
    end
  end

  assign collision_o   = col_q;
  assign pixel_row_o   = pix_q;
  assign sprite_done_o = done_q;

endmodule

`default_nettype wire

[rtl/sprite_xor_framebuffer_top.sv]
// Top level of the sprite XOR framebuffer: controller plus datapath.
//
//   Channel | Handshake              | Word
//   --------+------------------------+--------------------------------------------------
//   input   | in_valid_i, in_stall_o | command, start_x, start_y, row_offset, row_bits,
//           |                        | last_row
//   output  | out_valid_o, out_stall_i | collision, pixel_row, sprite_done
//
// For every word, the line address is formed on accept and the RAM read
// is issued; the next cycle merges, writes back and loads the result register.
// A new word is not taken while one executes: the next word's RAM read must come after
// this word's write back, so input stalls during the execute cycle.
// Reset zeroes the line valid bits, so the whole screen reads as clear at once.
// A stalled result holds in its register; input also stalls while it cannot drain.
`default_nettype none

module sprite_xor_framebuffer_top #(
  parameter int unsigned SCREEN_WIDTH  = sxf_pkg::SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = sxf_pkg::SCREEN_HEIGHT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [sxf_pkg::CMD_W-1:0]     command_i,
  input  wire logic [sxf_pkg::COORD_W-1:0]   start_x_i,
  input  wire logic [sxf_pkg::COORD_W-1:0]   start_y_i,
  input  wire logic [sxf_pkg::ROFF_W-1:0]    row_offset_i,
  input  wire logic [sxf_pkg::SPRITE_W-1:0]  row_bits_i,
  input  wire logic                          last_row_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               collision_o,
  output logic      [sxf_pkg::PIXEL_W-1:0]   pixel_row_o,
  output logic                               sprite_done_o
);

  sxf_pkg::ctl_t ctl;

  // Sequencer
  sxf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl)
  );

  // Framebuffer datapath
  sxf_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .command_i     (command_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .row_offset_i  (row_offset_i),
    .row_bits_i    (row_bits_i),
    .last_row_i    (last_row_i),
    .collision_o   (collision_o),
    .pixel_row_o   (pixel_row_o),
    .sprite_done_o (sprite_done_o)
  );

endmodule

`default_nettype wire
